FILE: rtl/mhpq_pkg.sv
// ----------------------------------------------------------------------------
// mhpq_pkg
// Shared types, field widths, codes and the signed key compare used by the
// min-heap priority queue.
// ----------------------------------------------------------------------------
`default_nettype none

package mhpq_pkg;

    localparam int KEY_W    = 32;
    localparam int STATUS_W = 2;
    localparam int FILL_W   = 7;

    typedef logic [KEY_W-1:0]    key_t;
    typedef logic [STATUS_W-1:0] status_t;
    typedef logic [FILL_W-1:0]   fill_t;

    localparam logic ACT_INSERT  = 1'b0;
    localparam logic ACT_EXTRACT = 1'b1;

    localparam status_t STATUS_OK    = 2'd0;
    localparam status_t STATUS_FULL  = 2'd1;
    localparam status_t STATUS_EMPTY = 2'd2;

    // signed less-than on two's complement key patterns
    function automatic logic key_less(input key_t a, input key_t b);
        return $signed(a) < $signed(b);
    endfunction

endpackage

`default_nettype wire

FILE: rtl/min_heap_priority_queue_unit.sv
// ----------------------------------------------------------------------------
// min_heap_priority_queue_unit
// Binary min-heap of signed 32-bit keys with insert and extract-min.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (req_valid / req_stall) carries one word: action and key_in.
//   action 0 inserts key_in, action 1 removes the smallest key.
//   rsp channel (rsp_valid / rsp_stall) returns one word per request:
//   key_out (removed key, zero otherwise), status (ok, full, empty) and
//   fill_count (keys held afterwards, low 7 bits).
//   One request is worked on at a time; req_stall is high while it runs.
//   All key compares go through one signed comparator under a small
//   sequencer, and the keys sit in a memory with one write and two reads.
//   Insert: the new key climbs from the last slot, each larger parent moving
//   down into the hole, until a parent is not larger or the root is reached.
//   Extract: the last key descends from the root, the smaller child (left on
//   a tie) moving up, until it has no child or no child is smaller than it.
//   A refused request (full or empty) goes straight to the done state.
//   The response sits in an output register; the next request is taken while
//   it waits, and a finished request waits in the done state while rsp_stall
//   holds the previous word.
//   Reset empties the queue (count to zero); stored keys are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module min_heap_priority_queue_unit #(
    parameter int CAPACITY = 64
) (
    input  wire                       clk,
    input  wire                       rst_n,
    input  wire                       req_valid,
    output logic                      req_stall,
    input  wire                       action,
    input  wire  signed [31:0]        key_in,
    output logic                      rsp_valid,
    input  wire                       rsp_stall,
    output logic signed [31:0]        key_out,
    output mhpq_pkg::status_t         status,
    output mhpq_pkg::fill_t           fill_count
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_UP_CHK = 3'd1;
    localparam logic [2:0] S_UP_CMP = 3'd2;
    localparam logic [2:0] S_EXT_LD = 3'd3;
    localparam logic [2:0] S_DN_CHK = 3'd4;
    localparam logic [2:0] S_DN_SEL = 3'd5;
    localparam logic [2:0] S_DN_CMP = 3'd6;
    localparam logic [2:0] S_DONE   = 3'd7;

    logic [2:0]          state_reg, state_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [AW-1:0]       pos_reg, pos_next;
    logic [AW-1:0]       pick_reg, pick_next;
    mhpq_pkg::key_t      hold_reg, hold_next;
    mhpq_pkg::key_t      child_reg, child_next;
    mhpq_pkg::key_t      res_key_reg, res_key_next;
    mhpq_pkg::status_t   res_status_reg, res_status_next;
    logic                rsp_valid_reg, rsp_valid_next;
    mhpq_pkg::key_t      key_out_reg;
    mhpq_pkg::status_t   status_reg;
    mhpq_pkg::fill_t     fill_reg;

    logic                mem_we;
    logic [AW-1:0]       mem_waddr;
    mhpq_pkg::key_t      mem_wdata;
    logic [AW-1:0]       mem_raddr_a;
    logic [AW-1:0]       mem_raddr_b;
    mhpq_pkg::key_t      mem_rdata_a;
    mhpq_pkg::key_t      mem_rdata_b;

    mhpq_pkg::key_t      cmp_lhs;
    mhpq_pkg::key_t      cmp_rhs;
    logic                cmp_less;

    logic [AW-1:0]       pos_m1;
    logic [AW-1:0]       parent;
    logic [CW:0]         child_l;
    logic [CW:0]         child_r;
    logic [CW:0]         count_ext;
    logic                req_take;
    logic                out_free;

    mhpq_store #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_store (
        .clk     (clk),
        .we      (mem_we),
        .waddr   (mem_waddr),
        .wdata   (mem_wdata),
        .raddr_a (mem_raddr_a),
        .raddr_b (mem_raddr_b),
        .rdata_a (mem_rdata_a),
        .rdata_b (mem_rdata_b)
    );

    assign pos_m1    = pos_reg - AW'(1);
    assign parent    = AW'(pos_m1 >> 1);
    assign child_l   = {CW'(pos_reg), 1'b1};
    assign child_r   = child_l + (CW+1)'(1);
    assign count_ext = {1'b0, count_reg};
    assign req_take  = req_valid && (state_reg == S_IDLE);
    assign out_free  = !rsp_valid_reg || !rsp_stall;

    // the one key comparator, operands chosen by the sequencer
    always_comb
    begin
        unique case (state_reg)
            S_DN_SEL:
            begin
                cmp_lhs = mem_rdata_b;
                cmp_rhs = mem_rdata_a;
            end
            S_DN_CMP:
            begin
                cmp_lhs = child_reg;
                cmp_rhs = hold_reg;
            end
            default:
            begin
                cmp_lhs = hold_reg;
                cmp_rhs = mem_rdata_a;
            end
        endcase
    end

    assign cmp_less = mhpq_pkg::key_less(cmp_lhs, cmp_rhs);

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        pos_next        = pos_reg;
        pick_next       = pick_reg;
        hold_next       = hold_reg;
        child_next      = child_reg;
        res_key_next    = res_key_reg;
        res_status_next = res_status_reg;
        rsp_valid_next  = rsp_valid_reg && rsp_stall;
        mem_we          = 1'b0;
        mem_waddr       = pos_reg;
        mem_wdata       = hold_reg;
        mem_raddr_a     = parent;
        mem_raddr_b     = child_r[AW-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                mem_raddr_a = '0;
                mem_raddr_b = AW'(count_reg - CW'(1));
                if (req_take)
                begin
                    res_key_next    = '0;
                    res_status_next = mhpq_pkg::STATUS_OK;
                    if (action == mhpq_pkg::ACT_INSERT)
                    begin
                        if (count_reg >= CW'(CAPACITY))
                        begin
                            res_status_next = mhpq_pkg::STATUS_FULL;
                            state_next      = S_DONE;
                        end
                        else
                        begin
                            hold_next  = key_in;
                            pos_next   = AW'(count_reg);
                            count_next = count_reg + CW'(1);
                            state_next = S_UP_CHK;
                        end
                    end
                    else
                    begin
                        if (count_reg == '0)
                        begin
                            res_status_next = mhpq_pkg::STATUS_EMPTY;
                            state_next      = S_DONE;
                        end
                        else
                        begin
                            count_next = count_reg - CW'(1);
                            state_next = S_EXT_LD;
                        end
                    end
                end
            end
            S_UP_CHK:
            begin
                if (pos_reg == '0)
                begin
                    mem_we     = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_UP_CMP;
                end
            end
            S_UP_CMP:
            begin
                mem_we = 1'b1;
                if (cmp_less)
                begin
                    // parent moves down into the hole
                    mem_wdata  = mem_rdata_a;
                    pos_next   = parent;
                    state_next = S_UP_CHK;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_EXT_LD:
            begin
                res_key_next = mem_rdata_a;
                hold_next    = mem_rdata_b;
                pos_next     = '0;
                state_next   = S_DN_CHK;
            end
            S_DN_CHK:
            begin
                mem_raddr_a = child_l[AW-1:0];
                if (child_l >= count_ext)
                begin
                    mem_we     = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_DN_SEL;
                end
            end
            S_DN_SEL:
            begin
                // right child only when present and strictly smaller
                if ((child_r < count_ext) && cmp_less)
                begin
                    child_next = mem_rdata_b;
                    pick_next  = child_r[AW-1:0];
                end
                else
                begin
                    child_next = mem_rdata_a;
                    pick_next  = child_l[AW-1:0];
                end
                state_next = S_DN_CMP;
            end
            S_DN_CMP:
            begin
                mem_we = 1'b1;
                if (cmp_less)
                begin
                    mem_wdata  = child_reg;
                    pos_next   = pick_reg;
                    state_next = S_DN_CHK;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg        <= pos_next;
        pick_reg       <= pick_next;
        hold_reg       <= hold_next;
        child_reg      <= child_next;
        res_key_reg    <= res_key_next;
        res_status_reg <= res_status_next;
        if ((state_reg == S_DONE) && out_free)
        begin
            key_out_reg <= res_key_reg;
            status_reg  <= res_status_reg;
            fill_reg    <= mhpq_pkg::FILL_W'(count_reg);
        end
    end

    assign req_stall  = (state_reg != S_IDLE);
    assign rsp_valid  = rsp_valid_reg;
    assign key_out    = key_out_reg;
    assign status     = status_reg;
    assign fill_count = fill_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall && (action == mhpq_pkg::ACT_INSERT)
            && (count_reg < CW'(CAPACITY)))
        |=> (count_reg == $past(count_reg) + CW'(1)))
        else $error("accepted insert did not grow the count");

    a_up_pos_inside: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_UP_CHK) || (state_reg == S_UP_CMP))
        |-> (CW'(pos_reg) < count_reg))
        else $error("sift-up position outside the heap");

    a_empty_reply: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (status == mhpq_pkg::STATUS_EMPTY))
        |-> ((fill_count == '0) && (key_out == '0)))
        else $error("empty reply with keys held or a key returned");

    a_no_bad_status: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (status != 2'd3))
        else $error("unused status code on output");

endmodule

`default_nettype wire

FILE: rtl/mhpq_store.sv
// ----------------------------------------------------------------------------
// mhpq_store
// Heap key storage: one write port and two read ports, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module mhpq_store #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  wire                   clk,
    input  wire                   we,
    input  wire  [AW-1:0]         waddr,
    input  wire  mhpq_pkg::key_t  wdata,
    input  wire  [AW-1:0]         raddr_a,
    input  wire  [AW-1:0]         raddr_b,
    output mhpq_pkg::key_t        rdata_a,
    output mhpq_pkg::key_t        rdata_b
);

    mhpq_pkg::key_t mem [DEPTH];
    mhpq_pkg::key_t rdata_a_reg;
    mhpq_pkg::key_t rdata_b_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a_reg <= mem[raddr_a];
        rdata_b_reg <= mem[raddr_b];
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

`default_nettype wire

FILE: tb/min_heap_priority_queue_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// min_heap_priority_queue_checker
// Watches the request and response channels of the min-heap queue, keeps a
// heap of its own fed by every accepted request word, and compares every
// accepted response word field by field with the oldest predicted one.
// ----------------------------------------------------------------------------
module min_heap_priority_queue_checker #(
    parameter int CAPACITY = 64
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  req_valid,
    input  wire                  req_stall,
    input  wire                  action,
    input  wire  [31:0]          key_in,
    input  wire                  rsp_valid,
    input  wire                  rsp_stall,
    input  wire  [31:0]          key_out,
    input  mhpq_pkg::status_t    status,
    input  mhpq_pkg::fill_t      fill_count,
    output int                   error_count,
    output int                   words_pending
);

    typedef struct packed {
        mhpq_pkg::key_t    key;
        mhpq_pkg::status_t status;
        mhpq_pkg::fill_t   fill;
    } reply_t;

    reply_t         reply_q[$];
    mhpq_pkg::key_t heap_keys[CAPACITY];
    int unsigned    heap_size;
    int             errors;
    reply_t         predicted;

    function automatic logic key_below(input mhpq_pkg::key_t a, input mhpq_pkg::key_t b);
        return $signed(a) < $signed(b);
    endfunction

    task automatic swap_keys(input int unsigned a, input int unsigned b);
        mhpq_pkg::key_t tmp;
        tmp          = heap_keys[a];
        heap_keys[a] = heap_keys[b];
        heap_keys[b] = tmp;
    endtask

    task automatic apply_heap_op(input logic act, input mhpq_pkg::key_t key,
                                 output reply_t rep);
        int unsigned pos;
        int unsigned left;
        int unsigned right;
        int unsigned pick;
        bit          moving;
        rep.key    = '0;
        rep.status = mhpq_pkg::STATUS_OK;
        if (act == mhpq_pkg::ACT_INSERT)
        begin
            if (heap_size >= CAPACITY)
                rep.status = mhpq_pkg::STATUS_FULL;
            else
            begin
                pos            = heap_size;
                heap_keys[pos] = key;
                heap_size++;
                // climb while strictly smaller than the parent
                while (pos > 0 && key_below(heap_keys[pos], heap_keys[(pos - 1) / 2]))
                begin
                    swap_keys(pos, (pos - 1) / 2);
                    pos = (pos - 1) / 2;
                end
            end
        end
        else
        begin
            if (heap_size == 0)
                rep.status = mhpq_pkg::STATUS_EMPTY;
            else
            begin
                rep.key = heap_keys[0];
                heap_size--;
                heap_keys[0] = heap_keys[heap_size];
                pos    = 0;
                moving = 1'b1;
                while (moving)
                begin
                    left  = 2 * pos + 1;
                    right = left + 1;
                    if (left >= heap_size)
                        moving = 1'b0;
                    else
                    begin
                        // left child wins a tie
                        pick = left;
                        if (right < heap_size && key_below(heap_keys[right], heap_keys[left]))
                            pick = right;
                        if (key_below(heap_keys[pick], heap_keys[pos]))
                        begin
                            swap_keys(pos, pick);
                            pos = pick;
                        end
                        else
                            moving = 1'b0;
                    end
                end
            end
        end
        rep.fill = heap_size[6:0];
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heap_size = 0;
            errors    = 0;
            reply_q.delete();
            error_count   <= 0;
            words_pending <= 0;
        end
        else
        begin
            if (req_valid && !req_stall)
            begin
                apply_heap_op(action, key_in, predicted);
                reply_q.push_back(predicted);
            end
            if (rsp_valid && !rsp_stall)
            begin
                if (reply_q.size() == 0)
                begin
                    $error("unexpected response word: key_out %0d status %0d fill_count %0d",
                           $signed(key_out), status, fill_count);
                    errors++;
                end
                else
                begin
                    predicted = reply_q.pop_front();
                    if (key_out !== predicted.key)
                    begin
                        $error("key_out: expected %0d, actual %0d",
                               $signed(predicted.key), $signed(key_out));
                        errors++;
                    end
                    if (status !== predicted.status)
                    begin
                        $error("status: expected %0d, actual %0d", predicted.status, status);
                        errors++;
                    end
                    if (fill_count !== predicted.fill)
                    begin
                        $error("fill_count: expected %0d, actual %0d",
                               predicted.fill, fill_count);
                        errors++;
                    end
                end
            end
            error_count   <= errors;
            words_pending <= reply_q.size();
        end
    end

endmodule

FILE: tb/tb_min_heap_priority_queue_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_min_heap_priority_queue_unit
// Drives insert and extract-min words into the heap queue: a directed part
// with extreme and equal keys and empty extracts, then random phases that
// fill the queue past full and drain it past empty, with random idling on
// both channels. The checker predicts and compares; this module gives the
// verdict.
// ----------------------------------------------------------------------------
module tb_min_heap_priority_queue_unit;

    localparam int CAPACITY = 64;
    localparam int BLOCKS   = 11;
    localparam int BLOCK_N  = 150;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              req_valid = 1'b0;
    logic              action    = mhpq_pkg::ACT_INSERT;
    logic [31:0]       key_in    = '0;
    logic              rsp_stall = 1'b0;
    logic              calm      = 1'b0;
    wire               req_stall;
    wire               rsp_valid;
    wire signed [31:0] key_out;
    mhpq_pkg::status_t status;
    mhpq_pkg::fill_t   fill_count;
    int                error_count;
    int                words_pending;

    min_heap_priority_queue_unit #(
        .CAPACITY   (CAPACITY)
    ) u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .action     (action),
        .key_in     (key_in),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .key_out    (key_out),
        .status     (status),
        .fill_count (fill_count)
    );

    min_heap_priority_queue_checker #(
        .CAPACITY      (CAPACITY)
    ) u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req_valid),
        .req_stall     (req_stall),
        .action        (action),
        .key_in        (key_in),
        .rsp_valid     (rsp_valid),
        .rsp_stall     (rsp_stall),
        .key_out       (key_out),
        .status        (status),
        .fill_count    (fill_count),
        .error_count   (error_count),
        .words_pending (words_pending)
    );

    always #4 clk = ~clk;

    function automatic bit take_break();
        return !calm && ($urandom_range(0, 99) < 22);
    endfunction

    always @(posedge clk)
        rsp_stall <= take_break();

    function automatic mhpq_pkg::key_t rand_key();
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 15) - 8;   // narrow range, many equal keys
            1:
            begin
                case ($urandom_range(0, 5))
                    0: return 32'h8000_0000;
                    1: return 32'h8000_0001;
                    2: return 32'h7FFF_FFFF;
                    3: return 32'h7FFF_FFFE;
                    4: return 32'h0000_0000;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    task automatic send_word(input logic act, input mhpq_pkg::key_t key);
        while (take_break())
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        action    <= act;
        key_in    <= key;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
    endtask

    // drop valid, then wait until every accepted word has its response
    task automatic wait_drained();
        req_valid <= 1'b0;
        @(posedge clk);
        while (words_pending != 0)
            @(posedge clk);
    endtask

    initial
    begin : stimulus
        int ins_pct;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // extract on an empty queue, once with a junk key
        send_word(mhpq_pkg::ACT_EXTRACT, 32'h0000_0000);
        send_word(mhpq_pkg::ACT_EXTRACT, 32'hDEAD_BEEF);
        // extremes and equal keys
        send_word(mhpq_pkg::ACT_INSERT, 32'h7FFF_FFFF);
        send_word(mhpq_pkg::ACT_INSERT, 32'h8000_0000);
        send_word(mhpq_pkg::ACT_INSERT, 32'h0000_0000);
        send_word(mhpq_pkg::ACT_INSERT, 32'hFFFF_FFFF);
        send_word(mhpq_pkg::ACT_INSERT, 32'h0000_0001);
        send_word(mhpq_pkg::ACT_INSERT, 32'h0000_0005);
        send_word(mhpq_pkg::ACT_INSERT, 32'h0000_0005);
        send_word(mhpq_pkg::ACT_INSERT, 32'h0000_0005);
        send_word(mhpq_pkg::ACT_INSERT, 32'h8000_0000);
        send_word(mhpq_pkg::ACT_INSERT, 32'h7FFF_FFFF);
        send_word(mhpq_pkg::ACT_INSERT, 32'hFFFF_FFFE);
        // drain all eleven and one more past empty
        repeat (12) send_word(mhpq_pkg::ACT_EXTRACT, $urandom);

        for (int blk = 0; blk < BLOCKS; blk++)
        begin
            // first block runs into full, second drains past empty
            if (blk == 0)
                ins_pct = 92;
            else if (blk == 1)
                ins_pct = 8;
            else
            begin
                case ($urandom_range(0, 2))
                    0: ins_pct = 85;
                    1: ins_pct = 50;
                    default: ins_pct = 15;
                endcase
            end
            calm <= (blk == 4);
            if (blk == 6)
                wait_drained();
            for (int n = 0; n < BLOCK_N; n++)
                send_word(($urandom_range(0, 99) >= ins_pct) ? mhpq_pkg::ACT_EXTRACT
                                                              : mhpq_pkg::ACT_INSERT,
                          rand_key());
        end

        wait_drained();
        repeat (40) @(posedge clk);
        if (error_count == 0 && words_pending == 0)
            $display("min_heap_priority_queue_unit regression: pass");
        else
            $display("min_heap_priority_queue_unit regression: fail");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("min_heap_priority_queue_unit regression: fail");
        $finish;
    end

endmodule

FILE: min_heap_priority_queue_unit.f
rtl/mhpq_pkg.sv
rtl/mhpq_store.sv
rtl/min_heap_priority_queue_unit.sv
tb/min_heap_priority_queue_checker.sv
tb/tb_min_heap_priority_queue_unit.sv
